// ===== hdl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue unit: operation
// codes, status codes and the command and result words.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Default storage geometry
  localparam int DEF_DEPTH      = 1024;
  localparam int DEF_DATA_WIDTH = 32;

  // Fixed field widths of the command and result words
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SIZE       = 3'd4,
    OP_EMPTY      = 3'd5,
    OP_PEEK_FRONT = 3'd6,
    OP_PEEK_BACK  = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY_ERR = 2'd1,
    ST_FULL_ERR  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                       func;
    logic signed [VALUE_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        item_count;
    logic                      is_empty;
    status_t                   status;
  } result_t;

endpackage

// ===== hdl/dq_ram.sv =====
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// The result word strobes on done in the cycle after the command is
//   taken. Throughput: one command per cycle while busy is low.
// The stored words sit in one RAM with registered read; head, tail and count
//   are flip-flops updated in the accept cycle.
// Reset (rst, synchronous): empties the deque; busy stays high for the cycle
//   after reset. Results cannot be stalled; done lasts one cycle.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH      = dq_pkg::DEF_DEPTH,
  parameter int DATA_WIDTH = dq_pkg::DEF_DATA_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  dq_pkg::cmd_t    cmd,
  output logic            done,
  output dq_pkg::result_t result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] cnt, cnt_next;

  logic                  accept;
  logic                  full, empty;
  logic [AW-1:0]         head_prev, head_succ, tail_prev, tail_succ;
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  logic                  rd_use, rd_use_next;
  dq_pkg::status_t       status, status_next;

  assign accept = start & ~busy;
  assign full   = (cnt == FULL_CNT);
  assign empty  = (cnt == '0);

  // Wrap neighbors of both ends
  assign head_prev = (head == '0) ? LAST_SLOT : head - 1'b1;
  assign head_succ = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign tail_prev = (tail == '0) ? LAST_SLOT : tail - 1'b1;
  assign tail_succ = (tail == LAST_SLOT) ? '0 : tail + 1'b1;

  assign wdata = DATA_WIDTH'(cmd.push_value);

  // Decode the command: pick the RAM access and the new pointers.
  // A write commits at the accept edge, so a read issued by the next
  // command already sees it; no entry is read and written by one command.
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    cnt_next    = cnt;
    we          = 1'b0;
    waddr       = tail;
    raddr       = head;
    rd_use_next = 1'b0;
    status_next = dq_pkg::ST_OK;
    if (accept) begin
      case (cmd.func)
        dq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_next = dq_pkg::ST_FULL_ERR;
          end else begin
            we        = 1'b1;
            waddr     = head_prev;
            head_next = head_prev;
            cnt_next  = cnt + 1'b1;
          end
        end
        dq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_next = dq_pkg::ST_FULL_ERR;
          end else begin
            we        = 1'b1;
            waddr     = tail;
            tail_next = tail_succ;
            cnt_next  = cnt + 1'b1;
          end
        end
        dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT: begin
          if (empty) begin
            status_next = dq_pkg::ST_EMPTY_ERR;
          end else begin
            raddr       = head;
            rd_use_next = 1'b1;
            if (cmd.func == dq_pkg::OP_POP_FRONT) begin
              head_next = head_succ;
              cnt_next  = cnt - 1'b1;
            end
          end
        end
        dq_pkg::OP_POP_BACK, dq_pkg::OP_PEEK_BACK: begin
          if (empty) begin
            status_next = dq_pkg::ST_EMPTY_ERR;
          end else begin
            raddr       = tail_prev;
            rd_use_next = 1'b1;
            if (cmd.func == dq_pkg::OP_POP_BACK) begin
              tail_next = tail_prev;
              cnt_next  = cnt - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Hold pointers and count; advance the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      cnt    <= '0;
      busy   <= 1'b1;
      done   <= 1'b0;
      rd_use <= 1'b0;
      status <= dq_pkg::ST_OK;
    end else begin
      head   <= head_next;
      tail   <= tail_next;
      cnt    <= cnt_next;
      busy   <= 1'b0;
      done   <= accept;
      rd_use <= rd_use_next;
      status <= status_next;
    end
  end

  // Drive the result word; the count is already the post-operation value
  always_comb begin
    result.read_value = rd_use ? dq_pkg::VALUE_W'(signed'(rdata)) : '0;
    result.item_count = dq_pkg::COUNT_W'(cnt);
    result.is_empty   = (cnt == '0);
    result.status     = status;
  end

endmodule

// ===== hdl/dq_checker.sv =====
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks for the double-ended queue unit, bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input dq_pkg::result_t result
);

  // Every taken command answers in the next cycle
  a_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted command gave no result");

  // No result without a command taken the cycle before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without a command");

  // Errors return a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != dq_pkg::ST_OK) |-> (result.read_value == '0))
    else $error("error result carries data");

  // A rejected push means the deque is full, hence not empty
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == dq_pkg::ST_FULL_ERR) |-> !result.is_empty)
    else $error("full status on empty deque");

  // An empty error only when nothing was stored
  a_empty_err: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == dq_pkg::ST_EMPTY_ERR) |-> result.is_empty)
    else $error("empty status on non-empty deque");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
